[rtl/sli_pkg.sv]
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list
// Operation and status codes, field widths, controller states and the
// structs that pass between the controller and the row of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int DATA_W   = 32;
	localparam int INDEX_W  = 7;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 7;
	localparam int COUNT_W  = 8;

	// stream word widths, padded to whole bytes
	localparam int IN_BITS   = OP_W + DATA_W + INDEX_W;
	localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = STATUS_W + POS_W + DATA_W + COUNT_W;
	localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

	// controller states
	localparam logic FSM_IDLE = 1'b0;
	localparam logic FSM_UPD  = 1'b1;

	// controller to cell
	typedef struct packed {
		logic            cmp_en;
		logic            upd_en;
		logic [OP_W-1:0] op;
	} cell_ctl_t;

	// cell to controller
	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_hit_t;

endpackage

`default_nettype wire

[rtl/sli_cell.sv]
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted list
// Holds one entry and its valid bit. On the compare cycle it registers its
// flags against the broadcast value and index; on the update cycle it
// takes the new value, or the entry of its upper or lower neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_cell
	import sli_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire logic [DATA_W-1:0] cmp_value,
	input  wire logic [INDEX_W-1:0] cmp_index,
	input  wire logic [DATA_W-1:0] upd_value,
	input  wire logic [DATA_W-1:0] prev_entry,
	input  wire logic              prev_valid,
	input  wire logic              prev_gt,
	input  wire logic              prev_eq,
	input  wire logic [DATA_W-1:0] next_entry,
	input  wire logic              next_valid,
	output logic [DATA_W-1:0]      entry,
	output logic                   valid,
	output logic                   gt,
	output logic                   eq,
	output cell_hit_t              hit,
	output logic [DATA_W-1:0]      rd_data
);

	logic [DATA_W-1:0] entry_q;
	logic              valid_q;
	logic              gt_q;
	logic              ge_q;
	logic              eq_q;
	logic              sel_q;

	// compare flags, taken when a word is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q  <= 1'b0;
			ge_q  <= 1'b0;
			eq_q  <= 1'b0;
			sel_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			// an empty slot counts as smaller than anything
			gt_q  <= !valid_q || (cmp_value > entry_q);
			ge_q  <= valid_q && (cmp_value >= entry_q);
			eq_q  <= valid_q && (cmp_value == entry_q);
			sel_q <= valid_q && (int'(cmp_index) == INDEX);
		end
	end

	// valid bit follows the data shifts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.upd_en) begin
			unique case (ctl.op)
				OP_INSERT: begin
					if (prev_gt) begin
						valid_q <= prev_valid;
					end else if (gt_q) begin
						valid_q <= 1'b1;
					end
				end
				OP_DELETE: begin
					if (ge_q) begin
						valid_q <= next_valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// entry data: shift down on insert, up on delete
	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			unique case (ctl.op)
				OP_INSERT: begin
					if (prev_gt) begin
						entry_q <= prev_entry;
					end else if (gt_q) begin
						entry_q <= upd_value;
					end
				end
				OP_DELETE: begin
					if (ge_q) begin
						entry_q <= next_entry;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign entry   = entry_q;
	assign valid   = valid_q;
	assign gt      = gt_q;
	assign eq      = eq_q;
	// first cell of each flag run marks the position
	assign hit.ins = gt_q && !prev_gt;
	assign hit.del = eq_q && !prev_eq;
	assign hit.rd  = sel_q;
	assign rd_data = sel_q ? entry_q : '0;

endmodule

`default_nettype wire

[rtl/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: descending sorted list with insert/delete/read
// Each input word is registered with the cell compare flags; the update step
// then shifts the cell row and loads the result word into the output register.
// No new word is taken until the update is done; a full output register stalls it.
// Reset clears the entry count and every cell's valid bit; entry data is
// not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete
	import sli_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// op[1:0], value[33:2], index[40:34], zero pad
	input  wire logic [IN_TW-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// status[1:0], position[8:2], read_value[40:9], entry_count[48:41], zero pad
	output logic [OUT_TW-1:0]      m_tdata
);

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                state_q;
	logic [OP_W-1:0]     op_s1;
	logic [DATA_W-1:0]   value_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic [CW-1:0]       count_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    position_q;
	logic [DATA_W-1:0]   read_value_q;
	logic [COUNT_W-1:0]  entry_count_q;

	logic                accept;
	logic                upd_go;
	logic                full;
	logic                found;
	logic                rd_ok;
	logic [PW-1:0]       ins_pos;
	logic [PW-1:0]       del_pos;
	logic [DATA_W-1:0]   rd_word;
	cell_ctl_t           ctl;

	logic [DATA_W-1:0]   c_entry [CAPACITY];
	logic                c_valid [CAPACITY];
	logic                c_gt    [CAPACITY];
	logic                c_eq    [CAPACITY];
	cell_hit_t           c_hit   [CAPACITY];
	logic [DATA_W-1:0]   c_rd    [CAPACITY];

	// handshakes
	assign s_tready = (state_q == FSM_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign upd_go   = (state_q == FSM_UPD) && (!out_valid_q || m_tready);
	assign full     = (count_q == CW'(CAPACITY));

	// cell row control
	always_comb begin
		ctl.cmp_en = accept;
		ctl.op     = op_s1;
		ctl.upd_en = upd_go
			&& !((op_s1 == OP_INSERT) && full)
			&& !((op_s1 == OP_DELETE) && !found);
	end

	// row of list cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] p_entry;
		logic              p_valid;
		logic              p_gt;
		logic              p_eq;
		logic [DATA_W-1:0] n_entry;
		logic              n_valid;

		if (i == 0) begin : g_first
			assign p_entry = '0;
			assign p_valid = 1'b0;
			assign p_gt    = 1'b0;
			assign p_eq    = 1'b0;
		end else begin : g_mid
			assign p_entry = c_entry[i-1];
			assign p_valid = c_valid[i-1];
			assign p_gt    = c_gt[i-1];
			assign p_eq    = c_eq[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign n_entry = '0;
			assign n_valid = 1'b0;
		end else begin : g_body
			assign n_entry = c_entry[i+1];
			assign n_valid = c_valid[i+1];
		end

		sli_cell #(
			.INDEX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cmp_value (s_tdata[OP_W +: DATA_W]),
			.cmp_index (s_tdata[OP_W + DATA_W +: INDEX_W]),
			.upd_value (value_s1),
			.prev_entry(p_entry),
			.prev_valid(p_valid),
			.prev_gt   (p_gt),
			.prev_eq   (p_eq),
			.next_entry(n_entry),
			.next_valid(n_valid),
			.entry     (c_entry[i]),
			.valid     (c_valid[i]),
			.gt        (c_gt[i]),
			.eq        (c_eq[i]),
			.hit       (c_hit[i]),
			.rd_data   (c_rd[i])
		);
	end

	// gather hit positions and read data; at most one cell hits per kind
	always_comb begin
		ins_pos = '0;
		del_pos = '0;
		found   = 1'b0;
		rd_ok   = 1'b0;
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (c_hit[i].ins) begin
				ins_pos = ins_pos | PW'(i);
			end
			if (c_hit[i].del) begin
				del_pos = del_pos | PW'(i);
			end
			found   = found | c_hit[i].del;
			rd_ok   = rd_ok | c_hit[i].rd;
			rd_word = rd_word | c_rd[i];
		end
	end

	// controller state and latched word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else if (accept) begin
			state_q <= FSM_UPD;
		end else if (upd_go) begin
			state_q <= FSM_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= s_tdata[0 +: OP_W];
			value_s1 <= s_tdata[OP_W +: DATA_W];
			index_s1 <= s_tdata[OP_W + DATA_W +: INDEX_W];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.upd_en) begin
			unique case (op_s1)
				OP_INSERT: count_q <= count_q + CW'(1);
				OP_DELETE: count_q <= count_q - CW'(1);
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			unique case (op_s1)
				OP_INSERT: begin
					read_value_q <= '0;
					if (full) begin
						status_q      <= ST_FULL;
						position_q    <= '0;
						entry_count_q <= COUNT_W'(count_q);
					end else begin
						status_q      <= ST_OK;
						position_q    <= POS_W'(ins_pos);
						entry_count_q <= COUNT_W'(count_q + CW'(1));
					end
				end
				OP_DELETE: begin
					read_value_q <= '0;
					if (found) begin
						status_q      <= ST_OK;
						position_q    <= POS_W'(del_pos);
						entry_count_q <= COUNT_W'(count_q - CW'(1));
					end else begin
						status_q      <= ST_NOT_FOUND;
						position_q    <= '0;
						entry_count_q <= COUNT_W'(count_q);
					end
				end
				OP_READ: begin
					entry_count_q <= COUNT_W'(count_q);
					if (rd_ok) begin
						status_q     <= ST_OK;
						position_q   <= index_s1;
						read_value_q <= rd_word;
					end else begin
						status_q     <= ST_BAD_INDEX;
						position_q   <= '0;
						read_value_q <= '0;
					end
				end
				default: begin
					status_q      <= ST_OK;
					position_q    <= '0;
					read_value_q  <= '0;
					entry_count_q <= COUNT_W'(count_q);
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'({entry_count_q, read_value_q, position_q, status_q});

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_list_insert_delete
// Drives insert, delete and read words over the slave stream and checks
// every result word against a shadow copy of the descending list. A short
// directed table comes first, then random phases that grow the list, fill
// it past capacity under a long output stall, drain it and mix it again.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import sli_pkg::*;

	localparam int CAP       = 128;
	localparam int HOLD_CYC  = 300;
	localparam int TAIL_CYC  = 8;

	// result word bit offsets, lowest field first
	localparam int R_POS = STATUS_W;
	localparam int R_RD  = R_POS + POS_W;
	localparam int R_CNT = R_RD + DATA_W;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   read_value;
		logic [COUNT_W-1:0]  entry_count;
	} result_t;

	// one row of the directed table; typed rows carry their own result
	typedef struct {
		logic [OP_W-1:0]    op;
		logic [DATA_W-1:0]  value;
		logic [INDEX_W-1:0] index;
		bit                 typed;
		result_t            want;
	} step_t;

	localparam result_t NO_WANT = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// op, value, index, zero pad
	logic [IN_TW-1:0]  s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// status, position, read_value, entry_count, zero pad
	logic [OUT_TW-1:0] m_tdata;

	// shadow list, position 0 holds the largest value
	logic [DATA_W-1:0] shadow_vals [CAP];
	int                shadow_len = 0;

	result_t pending_results [$];
	int      errors = 0;
	int      words_in = 0;
	int      words_out = 0;
	int      status_seen [4] = '{0, 0, 0, 0};
	int      peak_len = 0;
	bit      park_sink = 1'b0;
	bit      stim_done = 1'b0;

	sorted_list_insert_delete #(.CAPACITY(CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// apply one word to the shadow list and return its result
	function automatic result_t list_apply(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
			logic [INDEX_W-1:0] idx);
		result_t r;
		int      at;
		bit      hit;
		r = '0;
		at = 0;
		hit = 1'b0;
		case (op)
			OP_INSERT: begin
				if (shadow_len >= CAP) begin
					r.status = ST_FULL;
				end else begin
					at = shadow_len;
					for (int i = 0; i < shadow_len; i++) begin
						if (!hit && val > shadow_vals[i]) begin
							at = i;
							hit = 1'b1;
						end
					end
					for (int i = shadow_len; i > at; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[at] = val;
					shadow_len++;
					r.position = at[POS_W-1:0];
				end
			end
			OP_DELETE: begin
				for (int i = 0; i < shadow_len; i++) begin
					if (!hit && shadow_vals[i] == val) begin
						at = i;
						hit = 1'b1;
					end
				end
				if (!hit) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int i = at; i + 1 < shadow_len; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_len--;
					r.position = at[POS_W-1:0];
				end
			end
			OP_READ: begin
				if (int'(idx) >= shadow_len) begin
					r.status = ST_BAD_INDEX;
				end else begin
					r.position = idx;
					r.read_value = shadow_vals[idx];
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_len[COUNT_W-1:0];
		return r;
	endfunction

	// values: extremes, a small pool with repeats across all bits, or anything
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return $urandom_range(0, 15) * 32'h1111_1111;
			default: return $urandom;
		endcase
	endfunction

	// a delete mostly aims at a stored value
	function automatic logic [DATA_W-1:0] pick_victim();
		if (shadow_len > 0 && $urandom_range(0, 3) != 0)
			return shadow_vals[$urandom_range(0, shadow_len - 1)];
		return pick_value();
	endfunction

	// a read mostly lands at or just past the stored range
	function automatic logic [INDEX_W-1:0] pick_index();
		int k;
		if ($urandom_range(0, 4) == 0)
			return INDEX_W'($urandom_range(0, CAP - 1));
		k = $urandom_range(0, shadow_len);
		if (k > CAP - 1)
			k = CAP - 1;
		return k[INDEX_W-1:0];
	endfunction

	// gap draw with occasional back-to-back stretches
	function automatic int draw_gap(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	int src_calm = 0;
	int sink_calm = 0;

	// offer one word, wait for acceptance, then record what it must produce
	task automatic send_word(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
			logic [INDEX_W-1:0] idx, bit typed, result_t want);
		int                gap;
		logic [IN_TW-1:0]  w;
		result_t           got;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w = '0;
		w[OP_W-1:0] = op;
		w[OP_W +: DATA_W] = val;
		w[OP_W + DATA_W +: INDEX_W] = idx;
		s_tdata <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		got = list_apply(op, val, idx);
		pending_results.push_back(typed ? want : got);
		words_in++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
	endtask

	task automatic send_mixed(int n, int ins_pct, int del_pct);
		int roll;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				send_word(OP_INSERT, pick_value(), INDEX_W'($urandom), 1'b0, NO_WANT);
			else if (roll < ins_pct + del_pct)
				send_word(OP_DELETE, pick_victim(), INDEX_W'($urandom), 1'b0, NO_WANT);
			else if (roll < 96)
				send_word(OP_READ, $urandom, pick_index(), 1'b0, NO_WANT);
			else
				send_word(OP_NONE, $urandom, INDEX_W'($urandom), 1'b0, NO_WANT);
		end
	endtask

	// stimulus
	initial begin
		step_t plan [$];
		int    full_hits;
		plan = '{
			'{OP_READ,   32'h0,         7'd0,   1'b1, '{ST_BAD_INDEX, 7'd0, 32'd0, 8'd0}},
			'{OP_DELETE, 32'd5,         7'd0,   1'b1, '{ST_NOT_FOUND, 7'd0, 32'd0, 8'd0}},
			'{OP_NONE,   32'hFFFF_FFFF, 7'd127, 1'b1, '{ST_OK,        7'd0, 32'd0, 8'd0}},
			'{OP_INSERT, 32'h0,         7'd0,   1'b1, '{ST_OK,        7'd0, 32'd0, 8'd1}},
			'{OP_INSERT, 32'hFFFF_FFFF, 7'd0,   1'b1, '{ST_OK,        7'd0, 32'd0, 8'd2}},
			'{OP_INSERT, 32'h0,         7'd0,   1'b0, NO_WANT},
			'{OP_INSERT, 32'h8000_0000, 7'd0,   1'b0, NO_WANT},
			'{OP_INSERT, 32'h8000_0000, 7'd0,   1'b0, NO_WANT},
			'{OP_INSERT, 32'h7FFF_FFFF, 7'd0,   1'b0, NO_WANT},
			'{OP_READ,   32'h0,         7'd0,   1'b0, NO_WANT},
			'{OP_READ,   32'h0,         7'd5,   1'b0, NO_WANT},
			'{OP_READ,   32'h0,         7'd6,   1'b1, '{ST_BAD_INDEX, 7'd0, 32'd0, 8'd6}},
			'{OP_READ,   32'hFFFF_FFFF, 7'd127, 1'b1, '{ST_BAD_INDEX, 7'd0, 32'd0, 8'd6}},
			'{OP_DELETE, 32'h8000_0000, 7'd0,   1'b0, NO_WANT},
			'{OP_DELETE, 32'h0,         7'd0,   1'b0, NO_WANT},
			'{OP_DELETE, 32'd12345,     7'd0,   1'b1, '{ST_NOT_FOUND, 7'd0, 32'd0, 8'd4}},
			'{OP_INSERT, 32'hAAAA_AAAA, 7'd0,   1'b0, NO_WANT},
			'{OP_INSERT, 32'h5555_5555, 7'd0,   1'b0, NO_WANT},
			'{OP_READ,   32'h0,         7'h55,  1'b1, '{ST_BAD_INDEX, 7'd0, 32'd0, 8'd6}},
			'{OP_READ,   32'h0,         7'd1,   1'b0, NO_WANT},
			'{OP_NONE,   32'h0,         7'd42,  1'b1, '{ST_OK,        7'd0, 32'd0, 8'd6}},
			'{OP_DELETE, 32'hFFFF_FFFF, 7'd0,   1'b1, '{ST_OK,        7'd0, 32'd0, 8'd5}},
			'{OP_DELETE, 32'h0,         7'd0,   1'b0, NO_WANT},
			'{OP_READ,   32'h0,         7'd0,   1'b0, NO_WANT}
		};
		full_hits = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// directed table
		foreach (plan[k])
			send_word(plan[k].op, plan[k].value, plan[k].index, plan[k].typed, plan[k].want);

		// growth-biased mix
		send_mixed(500, 45, 30);

		// sender pause until every result is back
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		// fill past capacity while the sink stalls for a long stretch
		park_sink = 1'b1;
		while (full_hits < 12) begin
			if ($urandom_range(0, 99) < 85) begin
				if (shadow_len >= CAP)
					full_hits++;
				send_word(OP_INSERT, pick_value(), INDEX_W'($urandom), 1'b0, NO_WANT);
			end else begin
				send_word(OP_READ, $urandom, pick_index(), 1'b0, NO_WANT);
			end
		end

		// drain through deletes of stored values, with some noise
		while (shadow_len > 0) begin
			if ($urandom_range(0, 99) < 85)
				send_word(OP_DELETE, shadow_vals[$urandom_range(0, shadow_len - 1)],
					INDEX_W'($urandom), 1'b0, NO_WANT);
			else if ($urandom_range(0, 1) == 0)
				send_word(OP_DELETE, pick_value(), INDEX_W'($urandom), 1'b0, NO_WANT);
			else
				send_word(OP_READ, $urandom, pick_index(), 1'b0, NO_WANT);
		end
		send_word(OP_DELETE, pick_value(), INDEX_W'($urandom), 1'b0, NO_WANT);
		send_word(OP_READ, $urandom, 7'd0, 1'b0, NO_WANT);

		// balanced mix
		send_mixed(600, 35, 35);

		s_tvalid <= 1'b0;
		stim_done = 1'b1;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("words sent %0d, results checked %0d, peak list length %0d",
			words_in, words_out, peak_len);
		$display("status mix: ok %0d, not found %0d, full %0d, bad index %0d",
			status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
			status_seen[ST_BAD_INDEX]);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result sink with random stalls and one long hold-off
	initial begin
		int      stall;
		result_t want;
		result_t got;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (park_sink) begin
				park_sink = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end
			stall = draw_gap(sink_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.status      = m_tdata[STATUS_W-1:0];
			got.position    = m_tdata[R_POS +: POS_W];
			got.read_value  = m_tdata[R_RD +: DATA_W];
			got.entry_count = m_tdata[R_CNT +: COUNT_W];
			words_out++;
			status_seen[got.status]++;
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending: %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, got.position);
					errors++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value,
						got.read_value);
					errors++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						got.entry_count);
					errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#(20 * 400_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
